// ----- rtl/mes_pkg.sv -----
// mes_pkg: types, widths, mode codes and constants of the envelope smoother
// used by mes_ram users and by multichannel_envelope_smoother_core
// no dependencies
package mes_pkg;

  localparam int NUM_CHANNELS_DEF = 16;

  localparam int MODE_W  = 3;
  localparam int CHAN_W  = 6;
  localparam int VAL_W   = 16;
  localparam int TIME_W  = 26;
  localparam int DELTA_W = 20;
  localparam int RATE_W  = 20;
  localparam int SPEED_W = 16;
  localparam int EFF_W   = 24;

  localparam logic [MODE_W-1:0] MODE_TICK      = 3'd0;
  localparam logic [MODE_W-1:0] MODE_SET_HOLD  = 3'd1;
  localparam logic [MODE_W-1:0] MODE_SET       = 3'd2;
  localparam logic [MODE_W-1:0] MODE_LOAD      = 3'd3;
  localparam logic [MODE_W-1:0] MODE_RESET_ALL = 3'd4;

  localparam logic [SPEED_W-1:0] SPEED_MIN   = 16'd41;
  localparam logic [SPEED_W-1:0] SPEED_MAX   = 16'd40960;
  localparam logic [SPEED_W-1:0] SPEED_RESET = 16'd4096;

  localparam logic [TIME_W-1:0] TAU_MIN_US    = 26'd10000;
  localparam logic [TIME_W-1:0] RISE_RESET_US = 26'd250000;
  localparam logic [TIME_W-1:0] FALL_RESET_US = 26'd500000;
  localparam logic [TIME_W-1:0] HOLD_RESET_US = 26'd0;
  localparam logic [RATE_W-1:0] RATE_RESET    = 20'd0;

  localparam logic [19:0] USEC_PER_S = 20'd1000000;
  // ceil(2^21 / 3), exact for dividends below 2^19
  localparam logic [19:0] RECIP3     = 20'd699051;
  // ceil(2^44 / 15625), exact for dividends below 2^30; 1e6 = 64 * 15625
  localparam logic [31:0] RECIP15625 = 32'd1125899907;

  typedef struct packed {
    logic [MODE_W-1:0]  mode;
    logic [CHAN_W-1:0]  channel;
    logic [VAL_W-1:0]   value;
    logic               use_default_hold;
    logic [TIME_W-1:0]  hold_override_us;
    logic [DELTA_W-1:0] delta_us;
    logic [TIME_W-1:0]  rise_time_us;
    logic [TIME_W-1:0]  fall_time_us;
    logic [TIME_W-1:0]  default_hold_us;
    logic [RATE_W-1:0]  max_rate;
  } in_item_t;

  typedef struct packed {
    logic [CHAN_W-1:0] out_channel;
    logic [VAL_W-1:0]  weight;
    logic              last;
  } out_item_t;

  typedef struct packed {
    logic [VAL_W-1:0]  weight;
    logic [VAL_W-1:0]  target;
    logic [TIME_W-1:0] hold_left;
  } dyn_t;

  typedef struct packed {
    logic [TIME_W-1:0] rise;
    logic [TIME_W-1:0] fall;
    logic [TIME_W-1:0] dhold;
    logic [RATE_W-1:0] rate;
  } par_t;

  localparam par_t PAR_RESET = '{rise: RISE_RESET_US, fall: FALL_RESET_US,
                                 dhold: HOLD_RESET_US, rate: RATE_RESET};

endpackage

// ----- rtl/multichannel_envelope_smoother_core.sv -----
// multichannel envelope smoother: one item at a time, busy while working.
// set and set-with-hold pass through ST_SET; load writes from idle; reset-all writes each channel in turn.
// tick: each channel's step comes from the 20-step divider for x and the one
// shared multiplier (taylor terms, 8 squarings); the rate cap adds states CAP2 and CAP3.
// each result shows for one cycle on out_valid; the receiver cannot stall.
// reset: synchronous, clears control and per-entry valid bits (stores read as reset values)
module multichannel_envelope_smoother_core #(
  parameter int NUM_CHANNELS = mes_pkg::NUM_CHANNELS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  mes_pkg::in_item_t           in_item,
  output logic                        out_valid,
  output mes_pkg::out_item_t          out_item,
  input  logic                        cfg_we,
  input  logic [mes_pkg::SPEED_W-1:0] cfg_wdata
);

  localparam int CH_W   = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int CHAN_W = mes_pkg::CHAN_W;
  localparam int VAL_W  = mes_pkg::VAL_W;
  localparam int TIME_W = mes_pkg::TIME_W;
  localparam int RATE_W = mes_pkg::RATE_W;
  localparam int EFF_W  = mes_pkg::EFF_W;
  localparam int DYN_W  = $bits(mes_pkg::dyn_t);
  localparam int PAR_W  = $bits(mes_pkg::par_t);

  localparam logic [4:0] ST_IDLE = 5'd0;
  localparam logic [4:0] ST_SET  = 5'd1;
  localparam logic [4:0] ST_CLR  = 5'd2;
  localparam logic [4:0] ST_RD   = 5'd3;
  localparam logic [4:0] ST_PREP = 5'd4;
  localparam logic [4:0] ST_DIV  = 5'd5;
  localparam logic [4:0] ST_P2   = 5'd6;
  localparam logic [4:0] ST_P3   = 5'd7;
  localparam logic [4:0] ST_P4   = 5'd8;
  localparam logic [4:0] ST_D6   = 5'd9;
  localparam logic [4:0] ST_D24  = 5'd10;
  localparam logic [4:0] ST_TAY  = 5'd11;
  localparam logic [4:0] ST_SQ   = 5'd12;
  localparam logic [4:0] ST_MAG  = 5'd13;
  localparam logic [4:0] ST_CAP1 = 5'd14;
  localparam logic [4:0] ST_CAP2 = 5'd15;
  localparam logic [4:0] ST_WB   = 5'd16;
  localparam logic [4:0] ST_CAP3 = 5'd17;

  localparam logic [1:0] KIND_ZERO = 2'd0;
  localparam logic [1:0] KIND_ONE  = 2'd1;
  localparam logic [1:0] KIND_MID  = 2'd2;

  localparam logic [4:0] DIV_TAU_STEPS = 5'd20;
  localparam logic [4:0] SQ_STEPS      = 5'd8;

  // control registers
  logic [4:0]              state_r, state_nxt;
  logic [CH_W-1:0]         ch_r, ch_nxt;
  logic [4:0]              cnt_r, cnt_nxt;
  logic [NUM_CHANNELS-1:0] dvalid_r, dvalid_nxt;
  logic [NUM_CHANNELS-1:0] pvalid_r, pvalid_nxt;
  logic [mes_pkg::SPEED_W-1:0] speed_r, speed_nxt;
  logic                    out_valid_r, out_valid_nxt;

  // datapath registers
  mes_pkg::in_item_t  item_r, item_nxt;
  mes_pkg::out_item_t out_item_r, out_item_nxt;
  logic [CH_W-1:0]    rd_addr_r;
  logic [EFF_W-1:0]   eff_r, eff_nxt;
  logic [VAL_W-1:0]   cur_r, cur_nxt;
  logic [VAL_W-1:0]   tgt_keep_r, tgt_keep_nxt;
  logic [TIME_W-1:0]  hold_new_r, hold_new_nxt;
  logic               up_r, up_nxt;
  logic [VAL_W-1:0]   diff_r, diff_nxt;
  logic [RATE_W-1:0]  rate_r, rate_nxt;
  logic [TIME_W-1:0]  den_r, den_nxt;
  logic [TIME_W:0]    rem_r, rem_nxt;
  logic [19:0]        lo_r, lo_nxt;
  logic [19:0]        quo_r, quo_nxt;
  logic [1:0]         kind_r, kind_nxt;
  logic [23:0]        p2_r, p2_nxt;
  logic [19:0]        p3_r, p3_nxt;
  logic [15:0]        p4_r, p4_nxt;
  logic [17:0]        t6_r, t6_nxt;
  logic [11:0]        t24_r, t24_nxt;
  logic [31:0]        e_r, e_nxt;
  logic [VAL_W-1:0]   mag_r, mag_nxt;
  logic [43:0]        p_r, p_nxt;

  // memories
  logic              dyn_we, par_we;
  logic [CH_W-1:0]   dyn_waddr, par_waddr, rd_addr;
  mes_pkg::dyn_t     dyn_wdata, dyn_q;
  mes_pkg::par_t     par_wdata, par_q;
  logic [DYN_W-1:0]  dyn_rdata;
  logic [PAR_W-1:0]  par_rdata;

  // shared multiplier and helpers
  logic [31:0]       mul_a, mul_b;
  logic [63:0]       mul_p;
  logic              accept, chan_ok, last_ch;
  logic [27:0]       z;
  logic [TIME_W:0]   r2;
  logic              q_bit;
  logic [19:0]       q_final;
  logic [34:0]       e_sum;
  logic [VAL_W:0]    up_sum;
  logic [VAL_W-1:0]  res;
  logic              hold_nz;
  logic [TIME_W-1:0] eff_ext, tau_raw, tau;
  logic [VAL_W-1:0]  tgt_eff;
  logic              prep_up;

  mes_ram #(.WIDTH(DYN_W), .DEPTH(NUM_CHANNELS)) u_dyn_ram (
    .clk   (clk),
    .we    (dyn_we),
    .waddr (dyn_waddr),
    .wdata (dyn_wdata),
    .raddr (rd_addr),
    .rdata (dyn_rdata)
  );

  mes_ram #(.WIDTH(PAR_W), .DEPTH(NUM_CHANNELS)) u_par_ram (
    .clk   (clk),
    .we    (par_we),
    .waddr (par_waddr),
    .wdata (par_wdata),
    .raddr (rd_addr),
    .rdata (par_rdata)
  );

  assign busy      = (state_r != ST_IDLE);
  assign accept    = start && !busy;
  assign chan_ok   = ({1'b0, in_item.channel} < 7'(NUM_CHANNELS));
  assign last_ch   = (ch_r == CH_W'(NUM_CHANNELS - 1));
  assign rd_addr   = (state_r == ST_IDLE) ? in_item.channel[CH_W-1:0] : ch_r;
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // entries never written read as their reset values
  assign dyn_q = dvalid_r[rd_addr_r] ? mes_pkg::dyn_t'(dyn_rdata) : '0;
  assign par_q = pvalid_r[rd_addr_r] ? mes_pkg::par_t'(par_rdata) : mes_pkg::PAR_RESET;

  assign z = {quo_r, 8'h00};

  always_comb begin
    case (state_r)
      ST_IDLE: begin mul_a = 32'(in_item.delta_us); mul_b = 32'(speed_r); end
      ST_P2:   begin mul_a = 32'(z);                mul_b = 32'(z);       end
      ST_P3:   begin mul_a = 32'(p2_r);             mul_b = 32'(z);       end
      ST_P4:   begin mul_a = 32'(p3_r);             mul_b = 32'(z);       end
      ST_D6:   begin mul_a = 32'(p3_r[19:1]);       mul_b = 32'(mes_pkg::RECIP3); end
      ST_D24:  begin mul_a = 32'(p4_r[15:3]);       mul_b = 32'(mes_pkg::RECIP3); end
      ST_SQ:   begin mul_a = e_r;                   mul_b = e_r;          end
      ST_MAG:  begin mul_a = 32'(diff_r);           mul_b = 32'(0) - e_r; end
      ST_CAP1: begin mul_a = 32'(rate_r);           mul_b = 32'(eff_r);   end
      ST_CAP2: begin mul_a = 32'(mag_r);            mul_b = 32'(mes_pkg::USEC_PER_S); end
      ST_CAP3: begin mul_a = 32'(p_r[35:6]);        mul_b = mes_pkg::RECIP15625; end
      default: begin mul_a = '0;                    mul_b = '0;           end
    endcase
  end

  assign mul_p = 64'(mul_a) * 64'(mul_b);

  // restoring divider step
  assign r2      = {rem_r[TIME_W-1:0], lo_r[19]};
  assign q_bit   = (r2 >= {1'b0, den_r});
  assign q_final = {quo_r[18:0], q_bit};

  assign e_sum = (35'd1 << 32) - 35'(z) + 35'(p2_r >> 1) + 35'(t24_r) - 35'(t6_r);

  // hold countdown and tau selection
  assign eff_ext = TIME_W'(eff_r);
  assign hold_nz = (dyn_q.hold_left != '0);
  assign tgt_eff = (hold_nz && (dyn_q.target < dyn_q.weight)) ? dyn_q.weight : dyn_q.target;
  assign prep_up = (tgt_eff >= dyn_q.weight);
  assign tau_raw = prep_up ? par_q.rise : par_q.fall;
  assign tau     = (tau_raw < mes_pkg::TAU_MIN_US) ? mes_pkg::TAU_MIN_US : tau_raw;

  assign up_sum = {1'b0, cur_r} + {1'b0, mag_r};
  always_comb begin
    if (up_r) begin
      res = up_sum[VAL_W] ? {VAL_W{1'b1}} : up_sum[VAL_W-1:0];
    end else begin
      res = (mag_r > cur_r) ? '0 : cur_r - mag_r;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    ch_nxt        = ch_r;
    cnt_nxt       = cnt_r;
    dvalid_nxt    = dvalid_r;
    pvalid_nxt    = pvalid_r;
    speed_nxt     = speed_r;
    out_valid_nxt = 1'b0;
    item_nxt      = item_r;
    out_item_nxt  = out_item_r;
    eff_nxt       = eff_r;
    cur_nxt       = cur_r;
    tgt_keep_nxt  = tgt_keep_r;
    hold_new_nxt  = hold_new_r;
    up_nxt        = up_r;
    diff_nxt      = diff_r;
    rate_nxt      = rate_r;
    den_nxt       = den_r;
    rem_nxt       = rem_r;
    lo_nxt        = lo_r;
    quo_nxt       = quo_r;
    kind_nxt      = kind_r;
    p2_nxt        = p2_r;
    p3_nxt        = p3_r;
    p4_nxt        = p4_r;
    t6_nxt        = t6_r;
    t24_nxt       = t24_r;
    e_nxt         = e_r;
    mag_nxt       = mag_r;
    p_nxt         = p_r;
    dyn_we        = 1'b0;
    dyn_waddr     = ch_r;
    dyn_wdata     = '0;
    par_we        = 1'b0;
    par_waddr     = in_item.channel[CH_W-1:0];
    par_wdata     = '{rise: in_item.rise_time_us, fall: in_item.fall_time_us,
                      dhold: in_item.default_hold_us, rate: in_item.max_rate};

    if (cfg_we) begin
      if (cfg_wdata < mes_pkg::SPEED_MIN) begin
        speed_nxt = mes_pkg::SPEED_MIN;
      end else if (cfg_wdata > mes_pkg::SPEED_MAX) begin
        speed_nxt = mes_pkg::SPEED_MAX;
      end else begin
        speed_nxt = cfg_wdata;
      end
    end

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          item_nxt = in_item;
          ch_nxt   = in_item.channel[CH_W-1:0];
          eff_nxt  = mul_p[EFF_W+11:12];
          case (in_item.mode)
            mes_pkg::MODE_TICK: begin
              // channel 0 is read in the next cycle
              ch_nxt    = '0;
              state_nxt = ST_RD;
            end
            mes_pkg::MODE_SET_HOLD, mes_pkg::MODE_SET: begin
              if (chan_ok) begin
                state_nxt = ST_SET;
              end
            end
            mes_pkg::MODE_LOAD: begin
              if (chan_ok) begin
                par_we = 1'b1;
                pvalid_nxt[in_item.channel[CH_W-1:0]] = 1'b1;
              end
            end
            mes_pkg::MODE_RESET_ALL: begin
              ch_nxt    = '0;
              state_nxt = ST_CLR;
            end
            default: begin
              state_nxt = ST_IDLE;
            end
          endcase
        end
      end

      ST_SET: begin
        dyn_we    = 1'b1;
        dyn_wdata = '{weight: dyn_q.weight, target: item_r.value,
                      hold_left: dyn_q.hold_left};
        if (item_r.mode == mes_pkg::MODE_SET_HOLD) begin
          dyn_wdata.hold_left = item_r.use_default_hold ? par_q.dhold : item_r.hold_override_us;
        end
        dvalid_nxt[ch_r] = 1'b1;
        state_nxt = ST_IDLE;
      end

      ST_CLR: begin
        dyn_we    = 1'b1;
        dyn_wdata = '{weight: item_r.value, target: item_r.value, hold_left: '0};
        dvalid_nxt[ch_r] = 1'b1;
        ch_nxt = ch_r + CH_W'(1);
        if (last_ch) begin
          state_nxt = ST_IDLE;
        end
      end

      ST_RD: begin
        state_nxt = ST_PREP;
      end

      ST_PREP: begin
        cur_nxt      = dyn_q.weight;
        tgt_keep_nxt = dyn_q.target;
        if (hold_nz) begin
          hold_new_nxt = (dyn_q.hold_left > eff_ext) ? dyn_q.hold_left - eff_ext : '0;
        end else begin
          hold_new_nxt = dyn_q.hold_left;
        end
        up_nxt   = prep_up;
        diff_nxt = prep_up ? tgt_eff - dyn_q.weight : dyn_q.weight - tgt_eff;
        rate_nxt = par_q.rate;
        den_nxt  = tau;
        // x would reach 16.0: exp term is zero
        if ({6'b0, eff_r} >= {tau, 4'b0}) begin
          kind_nxt  = KIND_ONE;
          state_nxt = ST_MAG;
        end else begin
          rem_nxt     = (TIME_W+1)'(eff_r >> 4);
          lo_nxt      = {eff_r[3:0], 16'h0000};
          quo_nxt     = '0;
          cnt_nxt     = DIV_TAU_STEPS;
          state_nxt   = ST_DIV;
        end
      end

      ST_DIV: begin
        rem_nxt = q_bit ? r2 - {1'b0, den_r} : r2;
        lo_nxt  = {lo_r[18:0], 1'b0};
        quo_nxt = q_final;
        cnt_nxt = cnt_r - 5'd1;
        if (cnt_r == 5'd1) begin
          if (q_final == '0) begin
            kind_nxt  = KIND_ZERO;
            state_nxt = ST_MAG;
          end else begin
            state_nxt = ST_P2;
          end
        end
      end

      ST_P2: begin
        p2_nxt    = mul_p[55:32];
        state_nxt = ST_P3;
      end

      ST_P3: begin
        p3_nxt    = mul_p[51:32];
        state_nxt = ST_P4;
      end

      ST_P4: begin
        p4_nxt    = mul_p[47:32];
        state_nxt = ST_D6;
      end

      ST_D6: begin
        t6_nxt    = mul_p[38:21];
        state_nxt = ST_D24;
      end

      ST_D24: begin
        t24_nxt   = mul_p[32:21];
        state_nxt = ST_TAY;
      end

      ST_TAY: begin
        e_nxt     = (e_sum > 35'h0_FFFF_FFFF) ? 32'hFFFF_FFFF : e_sum[31:0];
        cnt_nxt   = SQ_STEPS;
        state_nxt = ST_SQ;
      end

      ST_SQ: begin
        e_nxt   = mul_p[63:32];
        cnt_nxt = cnt_r - 5'd1;
        if (cnt_r == 5'd1) begin
          kind_nxt  = KIND_MID;
          state_nxt = ST_MAG;
        end
      end

      ST_MAG: begin
        case (kind_r)
          KIND_ZERO: mag_nxt = '0;
          KIND_ONE:  mag_nxt = diff_r;
          KIND_MID:  mag_nxt = (e_r == '0) ? diff_r : mul_p[47:32];
          default:   mag_nxt = '0;
        endcase
        state_nxt = ST_CAP1;
      end

      ST_CAP1: begin
        p_nxt = mul_p[43:0];
        if ((rate_r != '0) && (eff_r != '0)) begin
          state_nxt = ST_CAP2;
        end else begin
          state_nxt = ST_WB;
        end
      end

      ST_CAP2: begin
        // cap below mag exactly when rate*eff < mag*1e6
        if (p_r < 44'(mul_p[35:0])) begin
          state_nxt = ST_CAP3;
        end else begin
          state_nxt = ST_WB;
        end
      end

      ST_CAP3: begin
        // rate*eff below 2^36 here, so (p >> 6) / 15625 by reciprocal
        mag_nxt   = mul_p[59:44];
        state_nxt = ST_WB;
      end

      ST_WB: begin
        dyn_we    = 1'b1;
        dyn_wdata = '{weight: res, target: tgt_keep_r, hold_left: hold_new_r};
        dvalid_nxt[ch_r] = 1'b1;
        out_valid_nxt = 1'b1;
        out_item_nxt  = '{out_channel: CHAN_W'(ch_r), weight: res, last: last_ch};
        ch_nxt = ch_r + CH_W'(1);
        state_nxt = last_ch ? ST_IDLE : ST_RD;
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      ch_r        <= '0;
      cnt_r       <= '0;
      dvalid_r    <= '0;
      pvalid_r    <= '0;
      speed_r     <= mes_pkg::SPEED_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ch_r        <= ch_nxt;
      cnt_r       <= cnt_nxt;
      dvalid_r    <= dvalid_nxt;
      pvalid_r    <= pvalid_nxt;
      speed_r     <= speed_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r     <= item_nxt;
    out_item_r <= out_item_nxt;
    rd_addr_r  <= rd_addr;
    eff_r      <= eff_nxt;
    cur_r      <= cur_nxt;
    tgt_keep_r <= tgt_keep_nxt;
    hold_new_r <= hold_new_nxt;
    up_r       <= up_nxt;
    diff_r     <= diff_nxt;
    rate_r     <= rate_nxt;
    den_r      <= den_nxt;
    rem_r      <= rem_nxt;
    lo_r       <= lo_nxt;
    quo_r      <= quo_nxt;
    kind_r     <= kind_nxt;
    p2_r       <= p2_nxt;
    p3_r       <= p3_nxt;
    p4_r       <= p4_nxt;
    t6_r       <= t6_nxt;
    t24_r      <= t24_nxt;
    e_r        <= e_nxt;
    mag_r      <= mag_nxt;
    p_r        <= p_nxt;
  end

endmodule

// ----- rtl/mes_ram.sv -----
// mes_ram: generic single-port-write, single-port-read synchronous ram
// registered read data; no dependencies
module mes_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule
